// ===== design/lltri_pkg.sv =====
// shared types and constants for the laser line peak triangulator
`timescale 1ns / 1ps
package lltri_pkg;

  localparam int COORD_BITS = 12;
  localparam int CENTER_COL = 1280;
  localparam int CENTER_ROW = 960;
  localparam int DEN_OFFSET = 20 * 256 - CENTER_COL;
  localparam int SQRT_STEPS = 28;
  localparam int DIV_STEPS = 48;
  localparam int CNT_W = 6;
  localparam logic [35:0] RAD_BASE = 36'd32112640000;

  typedef enum logic [1:0] {
    SEL_X,
    SEL_Y,
    SEL_Z
  } sel_t;

  typedef enum logic [2:0] {
    CFG_THRESH,
    CFG_COL_FIRST,
    CFG_COL_LIMIT,
    CFG_ROW_FIRST,
    CFG_ROW_LIMIT,
    CFG_COS,
    CFG_SIN
  } cfg_idx_t;

  typedef struct packed {
    logic search;
    logic sq_init;
    logic sq_step;
    logic mul_load;
    sel_t sel;
    logic div_step;
    logic store;
  } cmd_t;

  typedef struct packed {
    logic emit;
  } stat_t;

endpackage

// ===== design/lltri_ctrl.sv =====
// sequencer for pixel intake, square root, multiply and divide passes
`timescale 1ns / 1ps
module lltri_ctrl
  import lltri_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  row_end,
  input  logic  out_stall,
  input  stat_t stat,
  output logic  in_stall,
  output logic  out_valid,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    IDLE = 6'b000001,
    SQI  = 6'b000010,
    SQR  = 6'b000100,
    MUL  = 6'b001000,
    DIV  = 6'b010000,
    STO  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  sel_t sel, sel_next;
  logic pend, pend_next;
  logic accept;
  logic store;

  assign accept = in_valid && (state == IDLE);
  assign store = (state == STO) && !pend;
  assign in_stall = (state != IDLE);
  assign out_valid = pend;

  always_comb begin
    state_next = state;
    sel_next = sel;
    cnt_next = '0;
    unique case (state)
      IDLE: begin
        if (accept && row_end && stat.emit) state_next = SQI;
      end
      SQI: begin
        state_next = SQR;
        sel_next = SEL_X;
      end
      SQR: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
          state_next = MUL;
          cnt_next = '0;
        end
      end
      MUL: state_next = DIV;
      DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = STO;
          cnt_next = '0;
        end
      end
      STO: begin
        // hold until the previous point has left the output registers
        if (store) begin
          priority if (sel == SEL_Z) begin
            state_next = IDLE;
          end else if (sel == SEL_X) begin
            sel_next = SEL_Y;
            state_next = MUL;
          end else begin
            sel_next = SEL_Z;
            state_next = MUL;
          end
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_comb begin
    pend_next = pend;
    if (pend && !out_stall) pend_next = 1'b0;
    if (store && (sel == SEL_Z)) pend_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt <= '0;
      sel <= SEL_X;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      sel <= sel_next;
      pend <= pend_next;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.search = accept;
    cmd.sq_init = (state == SQI);
    cmd.sq_step = (state == SQR);
    cmd.mul_load = (state == MUL);
    cmd.sel = sel;
    cmd.div_step = (state == DIV);
    cmd.store = store;
  end

endmodule

// ===== design/lltri_datapath.sv =====
// config registers, peak search, square root, multiplier and divider
`timescale 1ns / 1ps
module lltri_datapath
  import lltri_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic [7:0]             brightness,
  input  logic [COORD_BITS-1:0]  column,
  input  logic [COORD_BITS-1:0]  row,
  input  logic                   row_end,
  output logic signed [31:0]     point_x,
  output logic signed [31:0]     point_z,
  output logic signed [31:0]     point_y,
  output logic [COORD_BITS-1:0]  peak_column,
  output logic [COORD_BITS-1:0]  peak_row
);

  logic [7:0] peak_threshold;
  logic [11:0] col_first, row_first;
  logic [12:0] col_limit, row_limit;
  logic signed [15:0] turn_cosine, turn_sine;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_threshold <= 8'd128;
      col_first <= 12'd1280;
      col_limit <= 13'd2360;
      row_first <= 12'd200;
      row_limit <= 13'd960;
      turn_cosine <= 16'sd32767;
      turn_sine <= 16'sd0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESH:    peak_threshold <= cfg_data[7:0];
        CFG_COL_FIRST: col_first <= cfg_data[11:0];
        CFG_COL_LIMIT: col_limit <= cfg_data[12:0];
        CFG_ROW_FIRST: row_first <= cfg_data[11:0];
        CFG_ROW_LIMIT: row_limit <= cfg_data[12:0];
        CFG_COS:       turn_cosine <= $signed(cfg_data);
        CFG_SIN:       turn_sine <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // peak search
  logic [7:0] best_value, bv_n;
  logic [COORD_BITS-1:0] best_column, bc_n;
  logic in_win, upd;

  assign in_win = (column >= col_first) && ({1'b0, column} < col_limit) &&
                  (row >= row_first) && ({1'b0, row} < row_limit);
  assign upd = in_win && (brightness > best_value);
  assign bv_n = upd ? brightness : best_value;
  assign bc_n = upd ? column : best_column;
  assign stat.emit = (bv_n > peak_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_value <= '0;
      best_column <= '0;
    end else if (cmd.search) begin
      if (row_end) begin
        best_value <= '0;
        best_column <= '0;
      end else begin
        best_value <= bv_n;
        best_column <= bc_n;
      end
    end
  end

  // row capture
  logic signed [12:0] d;
  logic signed [12:0] g;
  logic [12:0] den;
  logic [COORD_BITS-1:0] cap_col, cap_row;

  always_ff @(posedge clk) begin
    if (cmd.search && row_end) begin
      cap_col <= bc_n;
      cap_row <= row;
      d <= $signed({1'b0, bc_n}) - 13'(CENTER_COL);
      g <= 13'(CENTER_ROW) - $signed({1'b0, row});
      den <= {1'b0, bc_n} + 13'(DEN_OFFSET);
    end
  end

  // square root, two radicand bits a step
  logic signed [16:0] d17, d20;
  logic [15:0] d20_mag;
  logic [31:0] d20_sq;
  logic [55:0] rad;
  logic [27:0] root;
  logic [29:0] rem;
  logic [31:0] rem_sh, trial;
  logic sq_ge;

  assign d17 = 17'(d);
  assign d20 = (d17 <<< 4) + (d17 <<< 2);
  assign d20_mag = d20[16] ? 16'(-d20) : d20[15:0];
  assign d20_sq = d20_mag * d20_mag;
  assign rem_sh = {rem, rad[55:54]};
  assign trial = {2'b00, root, 2'b01};
  assign sq_ge = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      rad <= {RAD_BASE + 36'(d20_sq), 20'd0};
      root <= '0;
      rem <= '0;
    end else if (cmd.sq_step) begin
      rem <= sq_ge ? 30'(rem_sh - trial) : rem_sh[29:0];
      root <= {root[26:0], sq_ge};
      rad <= {rad[53:0], 2'b00};
    end
  end

  // multiply and load divider
  logic signed [19:0] num, ma;
  logic signed [28:0] mb;
  logic signed [48:0] prod;
  logic [47:0] mag, dvd;
  logic [24:0] dvsr;

  assign num = (20'(d) <<< 6) + (20'(d) <<< 4);

  always_comb begin
    unique case (cmd.sel)
      SEL_X: begin
        ma = num;
        mb = 29'(turn_cosine);
      end
      SEL_Y: begin
        ma = num;
        mb = 29'(turn_sine);
      end
      SEL_Z: begin
        ma = 20'(g);
        mb = $signed({1'b0, root});
      end
      default: begin
        ma = num;
        mb = 29'(turn_cosine);
      end
    endcase
  end

  assign prod = ma * mb;
  assign mag = prod[48] ? 48'(-prod) : prod[47:0];
  assign dvd = (cmd.sel == SEL_Z) ? (mag << 6) : mag;
  assign dvsr = (cmd.sel == SEL_Z) ? (({12'd0, den} << 11) + ({12'd0, den} << 9))
                                   : {12'd0, den};

  // restoring divider, quotient shifts into the dividend register
  logic neg;
  logic [47:0] dq;
  logic [24:0] dv, rr;
  logic [25:0] r_sh;
  logic dv_ge;

  assign r_sh = {rr, dq[47]};
  assign dv_ge = (r_sh >= {1'b0, dv});

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      neg <= prod[48];
      dq <= dvd + 48'(dvsr >> 1);
      dv <= dvsr;
      rr <= '0;
    end else if (cmd.div_step) begin
      rr <= dv_ge ? 25'(r_sh - {1'b0, dv}) : r_sh[24:0];
      dq <= {dq[46:0], dv_ge};
    end
  end

  // sign and saturate
  logic signed [31:0] res;

  always_comb begin
    if (!neg) begin
      res = (dq > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(dq[31:0]);
    end else begin
      res = (dq > 48'h8000_0000) ? 32'sh8000_0000 : $signed(-dq[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      unique case (cmd.sel)
        SEL_X: point_x <= res;
        SEL_Y: point_y <= res;
        SEL_Z: point_z <= res;
        default: ;
      endcase
      peak_column <= cap_col;
      peak_row <= cap_row;
    end
  end

endmodule

// ===== design/laser_line_peak_triangulator_unit.sv =====
// top level of the laser line peak finder and triangulator
// throughput: one pixel per cycle inside a row; in_stall stays high after a row_end with a
//   point (28-step square root, 3 x 48-step divider), and longer while
//   the previous point still waits in the output registers
// reset: synchronous rst clears the sequencer and the peak search, loads register defaults
`timescale 1ns / 1ps
module laser_line_peak_triangulator_unit
  import lltri_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            brightness,
  input  logic [COORD_BITS-1:0] column,
  input  logic [COORD_BITS-1:0] row,
  input  logic                  row_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    point_x,
  output logic signed [31:0]    point_z,
  output logic signed [31:0]    point_y,
  output logic [COORD_BITS-1:0] peak_column,
  output logic [COORD_BITS-1:0] peak_row
);

  cmd_t cmd;
  stat_t stat;

  lltri_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .row_end   (row_end),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  lltri_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .brightness  (brightness),
    .column      (column),
    .row         (row),
    .row_end     (row_end),
    .point_x     (point_x),
    .point_z     (point_z),
    .point_y     (point_y),
    .peak_column (peak_column),
    .peak_row    (peak_row)
  );

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(point_x) && $stable(point_z) &&
      $stable(point_y) && $stable(peak_column) && $stable(peak_row)))
    else $error("pending point changed while stalled");

  a_single_point: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("point repeated");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

  a_out_needs_row_end: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && row_end))
    else $error("busy without row_end");

endmodule
